/* rtl/core/vobs_pkg.sv */
// ----------------------------------------------------------------------------
// Vertical overlap blend stitch package
// Shared types, sizes and register codes of the stitch block.
// ----------------------------------------------------------------------------
package vobs_pkg;

    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned MAX_OVERLAP = 64;
    localparam int unsigned MAX_ROWS    = 4095;

    localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
    localparam int unsigned SROW_W  = $clog2(MAX_OVERLAP);
    localparam int unsigned ADDR_W  = SROW_W + COL_W;
    localparam int unsigned ROW_W   = 12;
    localparam int unsigned NOVL_W  = 7;
    localparam int unsigned WIDTH_W = 11;
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned CFG_W   = 12;

    localparam int unsigned BLEND_W     = 8 + SROW_W;
    localparam int unsigned RECIP_SHIFT = BLEND_W + SROW_W;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [NOVL_W-1:0]  RESET_OVERLAP = NOVL_W'(30);
    localparam logic [WIDTH_W-1:0] RESET_WIDTH   = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]   RESET_HEIGHT  = ROW_W'(480);

    typedef enum logic [1:0] {
        CFG_OVERLAP_ROWS  = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_FIRST_HEIGHT  = 2'd2,
        CFG_SECOND_HEIGHT = 2'd3
    } vobs_cfg_idx_t;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_STORE = 2'd1,
        OP_BLEND = 2'd2
    } vobs_op_t;

    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [7:0] ch2;
    } vobs_in_t;

    typedef struct packed {
        logic [7:0] out0;
        logic [7:0] out1;
        logic [7:0] out2;
        logic       frame_end;
    } vobs_out_t;

    typedef struct packed {
        vobs_op_t            op;
        logic [ADDR_W-1:0]   addr;
        logic [PIX_W-1:0]    pix;
        logic [SROW_W-1:0]   row_j;
        logic [NOVL_W-1:0]   n_ovl;
        logic                last;
    } vobs_cmd_t;

endpackage

/* rtl/core/vobs_front.sv */
// ----------------------------------------------------------------------------
// Stitch front end
// Holds the configuration, counts rows and columns and classifies each item.
// ----------------------------------------------------------------------------
module vobs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [vobs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vobs_pkg::vobs_in_t            s_data,
    input  logic                          q_full,
    output logic                          q_push,
    output vobs_pkg::vobs_cmd_t           q_cmd
);

    logic [vobs_pkg::NOVL_W-1:0]  overlap_reg;
    logic [vobs_pkg::WIDTH_W-1:0] width_reg;
    logic [vobs_pkg::ROW_W-1:0]   h1_reg;
    logic [vobs_pkg::ROW_W-1:0]   h2_reg;

    logic [vobs_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [vobs_pkg::COL_W-1:0]   col_reg, col_next;
    logic                         phase_reg, phase_next;

    logic [vobs_pkg::NOVL_W-1:0]  n_eff;
    logic [vobs_pkg::WIDTH_W-1:0] w_eff;
    logic [vobs_pkg::ROW_W-1:0]   h1_eff;
    logic [vobs_pkg::ROW_W-1:0]   h2_eff;
    logic [vobs_pkg::ROW_W:0]     row_plus_n;
    logic [vobs_pkg::ROW_W:0]     row_plus_1;
    logic [vobs_pkg::SROW_W-1:0]  srow;
    logic                         row_end;
    logic                         last;
    vobs_pkg::vobs_op_t           op;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlap_reg <= vobs_pkg::RESET_OVERLAP;
            width_reg   <= vobs_pkg::RESET_WIDTH;
            h1_reg      <= vobs_pkg::RESET_HEIGHT;
            h2_reg      <= vobs_pkg::RESET_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                vobs_pkg::CFG_OVERLAP_ROWS: begin
                    overlap_reg <= cfg_data[vobs_pkg::NOVL_W-1:0];
                end
                vobs_pkg::CFG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data[vobs_pkg::WIDTH_W-1:0];
                end
                vobs_pkg::CFG_FIRST_HEIGHT: begin
                    h1_reg <= cfg_data[vobs_pkg::ROW_W-1:0];
                end
                vobs_pkg::CFG_SECOND_HEIGHT: begin
                    h2_reg <= cfg_data[vobs_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (overlap_reg == '0) begin
            n_eff = vobs_pkg::NOVL_W'(1);
        end else if (overlap_reg > vobs_pkg::NOVL_W'(vobs_pkg::MAX_OVERLAP)) begin
            n_eff = vobs_pkg::NOVL_W'(vobs_pkg::MAX_OVERLAP);
        end else begin
            n_eff = overlap_reg;
        end
        if (width_reg == '0) begin
            w_eff = vobs_pkg::WIDTH_W'(1);
        end else if (width_reg > vobs_pkg::WIDTH_W'(vobs_pkg::MAX_WIDTH)) begin
            w_eff = vobs_pkg::WIDTH_W'(vobs_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (h1_reg == '0) begin
            h1_eff = vobs_pkg::ROW_W'(1);
        end else if (h1_reg > vobs_pkg::ROW_W'(vobs_pkg::MAX_ROWS)) begin
            h1_eff = vobs_pkg::ROW_W'(vobs_pkg::MAX_ROWS);
        end else begin
            h1_eff = h1_reg;
        end
        if (h2_reg == '0) begin
            h2_eff = vobs_pkg::ROW_W'(1);
        end else if (h2_reg > vobs_pkg::ROW_W'(vobs_pkg::MAX_ROWS)) begin
            h2_eff = vobs_pkg::ROW_W'(vobs_pkg::MAX_ROWS);
        end else begin
            h2_eff = h2_reg;
        end
    end

    always_comb begin
        row_plus_n = {1'b0, row_reg} + (vobs_pkg::ROW_W + 1)'(n_eff);
        row_plus_1 = {1'b0, row_reg} + (vobs_pkg::ROW_W + 1)'(1);
        row_end    = ({1'b0, col_reg} + vobs_pkg::WIDTH_W'(1)) >= w_eff;
        srow       = row_reg[vobs_pkg::SROW_W-1:0];
        op         = vobs_pkg::OP_PASS;
        last       = 1'b0;
        if (!phase_reg) begin
            if (row_plus_n >= {1'b0, h1_eff}) begin
                op   = vobs_pkg::OP_STORE;
                srow = vobs_pkg::SROW_W'(row_plus_n - {1'b0, h1_eff});
            end
        end else begin
            if (row_reg < vobs_pkg::ROW_W'(n_eff)) begin
                op = vobs_pkg::OP_BLEND;
            end
            last = row_end && (row_plus_1 >= {1'b0, h2_eff});
        end

        q_cmd.op    = op;
        q_cmd.addr  = {srow, col_reg};
        q_cmd.pix   = {s_data.ch2, s_data.ch1, s_data.ch0};
        q_cmd.row_j = row_reg[vobs_pkg::SROW_W-1:0];
        q_cmd.n_ovl = n_eff;
        q_cmd.last  = last;

        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        if (row_end) begin
            col_next = '0;
            if (!phase_reg) begin
                if (row_plus_1 >= {1'b0, h1_eff}) begin
                    phase_next = 1'b1;
                    row_next   = '0;
                end else begin
                    row_next = row_plus_1[vobs_pkg::ROW_W-1:0];
                end
            end else if (last) begin
                phase_next = 1'b0;
                row_next   = '0;
            end else begin
                row_next = row_plus_1[vobs_pkg::ROW_W-1:0];
            end
        end else begin
            col_next = col_reg + vobs_pkg::COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= 1'b0;
        end else if (q_push) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* rtl/core/vobs_queue.sv */
// ----------------------------------------------------------------------------
// Stitch command queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module vobs_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  vobs_pkg::vobs_cmd_t   push_cmd,
    input  logic                  pop,
    output vobs_pkg::vobs_cmd_t   head_cmd,
    output logic                  full,
    output logic                  empty
);

    localparam int unsigned PtrW = $clog2(vobs_pkg::QUEUE_DEPTH);
    localparam int unsigned CntW = PtrW + 1;

    vobs_pkg::vobs_cmd_t  entry_reg [vobs_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]      wr_ptr_reg;
    logic [PtrW-1:0]      rd_ptr_reg;
    logic [CntW-1:0]      count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = count_reg == CntW'(vobs_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(vobs_pkg::QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("Queue count did not grow on a push.");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("Queue count did not shrink on a pop.");

endmodule

/* rtl/core/vobs_back.sv */
// ----------------------------------------------------------------------------
// Stitch back end
// Owns the overlap line store and blends stored rows with incoming rows.
// ----------------------------------------------------------------------------
module vobs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vobs_pkg::vobs_cmd_t   head_cmd,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vobs_pkg::vobs_out_t   m_data
);

    localparam int unsigned ProdW = vobs_pkg::BLEND_W + vobs_pkg::RECIP_W;
    localparam int unsigned MemDepth = vobs_pkg::MAX_OVERLAP * vobs_pkg::MAX_WIDTH;

    typedef struct packed {
        vobs_pkg::vobs_op_t               op;
        logic [vobs_pkg::PIX_W-1:0]       pix;
        logic [vobs_pkg::SROW_W-1:0]      row_j;
        logic [vobs_pkg::NOVL_W-1:0]      n_ovl;
        logic                             last;
    } stage_t;

    logic [vobs_pkg::PIX_W-1:0]   store_mem [MemDepth];
    logic [vobs_pkg::RECIP_W-1:0] recip_tab [vobs_pkg::MAX_OVERLAP];

    logic                         adv;
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    stage_t                       s1_reg, s2_reg, s3_reg;
    logic [vobs_pkg::PIX_W-1:0]   rd_reg;
    logic [vobs_pkg::BLEND_W:0]   pa_reg [3];
    logic [vobs_pkg::BLEND_W:0]   pb_reg [3];
    logic [vobs_pkg::BLEND_W-1:0] x_reg [3];
    logic [vobs_pkg::RECIP_W-1:0] recip_reg;
    logic [vobs_pkg::NOVL_W-1:0]  n_minus_j;
    logic [7:0]                   quot [3];
    logic [ProdW-1:0]             prod [3];
    vobs_pkg::vobs_out_t          out_reg, out_next;

    for (genvar d = 0; d < vobs_pkg::MAX_OVERLAP; d++) begin : g_recip
        localparam int unsigned Div = d + 1;
        localparam logic [vobs_pkg::RECIP_W-1:0] Recip =
            vobs_pkg::RECIP_W'(((64'd1 << vobs_pkg::RECIP_SHIFT) + Div - 1) / Div);
        assign recip_tab[d] = Recip;
    end

    assign adv     = !out_valid_reg || m_ready;
    assign q_pop   = adv && !q_empty;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop && head_cmd.op == vobs_pkg::OP_STORE) begin
            store_mem[head_cmd.addr] <= head_cmd.pix;
        end
        if (q_pop && head_cmd.op == vobs_pkg::OP_BLEND) begin
            rd_reg <= store_mem[head_cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_pop && head_cmd.op != vobs_pkg::OP_STORE;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign n_minus_j = s1_reg.n_ovl - vobs_pkg::NOVL_W'(s1_reg.row_j);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = ProdW'(x_reg[c]) * ProdW'(recip_reg);
            quot[c] = prod[c][vobs_pkg::RECIP_SHIFT +: 8];
        end
        out_next.frame_end = s3_reg.last;
        if (s3_reg.op == vobs_pkg::OP_BLEND) begin
            out_next.out0 = quot[0];
            out_next.out1 = quot[1];
            out_next.out2 = quot[2];
        end else begin
            out_next.out0 = s3_reg.pix[7:0];
            out_next.out1 = s3_reg.pix[15:8];
            out_next.out2 = s3_reg.pix[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg.op    <= head_cmd.op;
            s1_reg.pix   <= head_cmd.pix;
            s1_reg.row_j <= head_cmd.row_j;
            s1_reg.n_ovl <= head_cmd.n_ovl;
            s1_reg.last  <= head_cmd.last;
            s2_reg       <= s1_reg;
            s3_reg       <= s2_reg;
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= (vobs_pkg::BLEND_W + 1)'(n_minus_j) *
                             (vobs_pkg::BLEND_W + 1)'(rd_reg[8*c +: 8]);
                pb_reg[c] <= (vobs_pkg::BLEND_W + 1)'(s1_reg.row_j) *
                             (vobs_pkg::BLEND_W + 1)'(s1_reg.pix[8*c +: 8]);
                x_reg[c]  <= vobs_pkg::BLEND_W'(pa_reg[c] + pb_reg[c]);
            end
            recip_reg <= recip_tab[vobs_pkg::SROW_W'(s2_reg.n_ovl - vobs_pkg::NOVL_W'(1))];
            out_reg   <= out_next;
        end
    end

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s3_valid_reg) && $stable(s2_valid_reg) && $stable(s1_valid_reg))
        else $error("Back end pipeline moved during a stall.");

    a_store_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && q_pop && head_cmd.op == vobs_pkg::OP_STORE |=> !s1_valid_reg)
        else $error("A stored item entered the result pipeline.");

    a_blend_n_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_reg.op == vobs_pkg::OP_BLEND |->
            s1_reg.n_ovl != '0 && vobs_pkg::NOVL_W'(s1_reg.row_j) < s1_reg.n_ovl)
        else $error("Blend row is not below the overlap.");

endmodule

/* rtl/core/vertical_overlap_blend_stitch_top.sv */
// ----------------------------------------------------------------------------
// Vertical overlap blend stitch, top level
// Joins two images of equal width along a linearly blended band of rows.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock and gives one result per clock when
// the result side keeps up; first-image overlap rows are absorbed and give no
// result. An item is taken into the four-entry queue at the edge that accepts
// it; the line store read, the weight products, their sum, and the reciprocal
// multiply that stands in for the divide by the overlap then each add one
// register stage. The line store holds 64 rows of 1024 pixels in one memory
// with a single access per cycle and is not cleared after reset, so the first
// image must fill the rows that the second image blends with. The user must
// write configuration only while idle; the block itself does not enforce it.
module vertical_overlap_blend_stitch_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [vobs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vobs_pkg::vobs_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vobs_pkg::vobs_out_t           m_data
);

    vobs_pkg::vobs_cmd_t push_cmd;
    vobs_pkg::vobs_cmd_t head_cmd;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;

    vobs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    vobs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    vobs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
